FILE: rtl/tcw_pkg.sv
// tcw_pkg: shared constants for the text console writer.
// Default geometry, character codes and operation codes.
// No dependencies.
package tcw_pkg;

  // Default geometry
  localparam int COLS_DEF  = 80;
  localparam int ROWS_DEF  = 25;
  localparam int TERMS_DEF = 4;

  // Character codes and fixed values
  localparam logic [7:0] CH_NEWLINE = 8'd10;
  localparam logic [7:0] CH_TAB     = 8'd9;
  localparam logic [7:0] CH_SPACE   = 8'd32;
  localparam int         TAB_STEP   = 4;
  localparam logic [7:0] ATTR_RESET = 8'd7;

  // Operation codes
  localparam logic [2:0] FN_PUT    = 3'd0;
  localparam logic [2:0] FN_ATTR   = 3'd1;
  localparam logic [2:0] FN_CLEAR  = 3'd2;
  localparam logic [2:0] FN_SELECT = 3'd3;
  localparam logic [2:0] FN_READ   = 3'd4;

endpackage

FILE: rtl/tcw_ram.sv
// tcw_ram: generic simple dual-port RAM, one write and one read port.
// Read data is registered. No dependencies.
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/text_console_writer_top.sv
// text_console_writer_top: bank of virtual text terminals over one cell RAM.
// Depends on tcw_pkg and tcw_ram.
//
// Takes one command item when start is high and busy is low, and returns one
// result item, marked by done for a single cycle; the receiver cannot stall,
// so it must take the result in that cycle. Set attribute, select visible and
// put char without a scroll give their result from the execute state; read
// cell passes through one more state, as the cell RAM has a registered read.
// Clear and a put char that scrolls walk the whole screen through the one RAM
// port pair, one cell per cycle, then give the result from a flush state.
// busy drops while done is high, so the next item can be taken at the edge
// that takes the result. After reset the block is busy while it fills every
// cell with a space of attribute zero.
module text_console_writer_top #(
  parameter int COLS  = tcw_pkg::COLS_DEF,
  parameter int ROWS  = tcw_pkg::ROWS_DEF,
  parameter int TERMS = tcw_pkg::TERMS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  func,
  input  logic [1:0]  term,
  input  logic [7:0]  char_code,
  input  logic [10:0] cell_index,
  output logic        done,
  output logic [10:0] cursor_pos,
  output logic        scrolled,
  output logic        refresh,
  output logic [1:0]  visible_term,
  output logic [7:0]  read_char,
  output logic [7:0]  read_attr
);

  localparam int CELLS = ROWS * COLS;
  localparam int TOTAL = TERMS * CELLS;
  localparam int AW    = $clog2(TOTAL);
  localparam int TW    = (TERMS > 1) ? $clog2(TERMS) : 1;
  localparam int CUW   = $clog2(CELLS + COLS);
  localparam int CUW1  = CUW + 1;
  localparam int COLW  = $clog2(COLS);
  localparam int COLW1 = COLW + 1;

  typedef enum logic [6:0] {
    ST_INIT   = 7'b0000001,
    ST_IDLE   = 7'b0000010,
    ST_EXEC   = 7'b0000100,
    ST_RDWAIT = 7'b0001000,
    ST_SCROLL = 7'b0010000,
    ST_CLEAR  = 7'b0100000,
    ST_FLUSH  = 7'b1000000
  } state_t;

  state_t state;

  // latched command item
  logic [2:0]    f_reg;
  logic [1:0]    t_reg;
  logic [7:0]    c_reg;
  logic [10:0]   i_reg;
  logic [AW-1:0] base;

  // per-terminal state
  logic [CUW-1:0]  cur_regs  [TERMS];
  logic [COLW-1:0] col_regs  [TERMS];
  logic [7:0]      attr_regs [TERMS];
  logic [1:0]      shown;

  // sweep counter and write-back stage
  logic [AW-1:0] p;
  logic          s_valid;
  logic [AW-1:0] s_addr;
  logic          s_blank;
  logic          s_clear;

  // RAM ports
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [15:0]   ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [15:0]   ram_rdata;

  // decode of the latched item
  logic [TW-1:0]   tsel;
  logic            t_ok;
  logic [CUW-1:0]  cur_now;
  logic [COLW-1:0] col_now;
  logic [7:0]      attr_now;
  logic [CUW1-1:0] cur_ext;
  logic [CUW1-1:0] cur_adv;
  logic [CUW1-1:0] cur_fin;
  logic [COLW1-1:0] col_sum;
  logic [COLW-1:0] col_fin;
  logic            wr_char;
  logic            wrap;
  logic            sweep_end;
  logic            scroll_rd;

  assign busy = (state != ST_IDLE);

  assign tsel     = TW'(t_reg);
  assign t_ok     = (32'(t_reg) < TERMS);
  assign cur_now  = cur_regs[tsel];
  assign col_now  = col_regs[tsel];
  assign attr_now = attr_regs[tsel];
  assign cur_ext  = {1'b0, cur_now};

  // cursor advance for put char
  always_comb begin
    wr_char = 1'b0;
    case (c_reg)
      tcw_pkg::CH_NEWLINE: begin
        cur_adv = CUW1'(cur_ext + CUW1'(COLS) - CUW1'(col_now));
        col_sum = '0;
      end
      tcw_pkg::CH_TAB: begin
        cur_adv = CUW1'(cur_ext + CUW1'(tcw_pkg::TAB_STEP));
        col_sum = COLW1'({1'b0, col_now} + COLW1'(tcw_pkg::TAB_STEP));
      end
      default: begin
        wr_char = 1'b1;
        cur_adv = CUW1'(cur_ext + CUW1'(1));
        col_sum = COLW1'({1'b0, col_now} + COLW1'(1));
      end
    endcase
    wrap = (cur_adv >= CUW1'(CELLS));
    // column wraps within one row span
    if (col_sum >= COLW1'(COLS)) begin
      col_fin = COLW'(col_sum - COLW1'(COLS));
    end else begin
      col_fin = COLW'(col_sum);
    end
    // a scroll pulls the cursor back one row
    if (wrap) begin
      cur_fin = CUW1'(cur_adv - CUW1'(COLS));
      if (cur_fin >= CUW1'(CELLS)) begin
        cur_fin = CUW1'(CELLS - 1);
        col_fin = COLW'(COLS - 1);
      end
    end else begin
      cur_fin = cur_adv;
    end
  end

  assign sweep_end = (p == AW'(CELLS - 1));
  assign scroll_rd = (p < AW'(CELLS - COLS));

  // RAM write port: init fill, sweep write-back, put char
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = p;
    ram_wdata = {8'h00, tcw_pkg::CH_SPACE};
    if (state == ST_INIT) begin
      ram_we = 1'b1;
    end else if (s_valid) begin
      ram_we    = 1'b1;
      ram_waddr = s_addr;
      if (s_clear) begin
        ram_wdata = {ram_rdata[15:8], tcw_pkg::CH_SPACE};
      end else if (s_blank) begin
        ram_wdata = {attr_now, tcw_pkg::CH_SPACE};
      end else begin
        ram_wdata = ram_rdata;
      end
    end else if (state == ST_EXEC && f_reg == tcw_pkg::FN_PUT && t_ok && wr_char) begin
      ram_we    = 1'b1;
      ram_waddr = AW'(base + AW'(cur_now));
      ram_wdata = {attr_now, c_reg};
    end
  end

  // RAM read port: read cell, scroll source row, clear read-modify-write
  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = AW'(base + AW'(i_reg));
    case (state)
      ST_EXEC: begin
        ram_re = (f_reg == tcw_pkg::FN_READ) && t_ok && (32'(i_reg) < CELLS);
      end
      ST_SCROLL: begin
        ram_re    = scroll_rd;
        ram_raddr = AW'(base + p + AW'(COLS));
      end
      ST_CLEAR: begin
        ram_re    = 1'b1;
        ram_raddr = AW'(base + p);
      end
      default: begin
        ram_re = 1'b0;
      end
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_INIT;
      p       <= '0;
      s_valid <= 1'b0;
      done    <= 1'b0;
      shown   <= '0;
      for (int i = 0; i < TERMS; i++) begin
        cur_regs[i]  <= '0;
        col_regs[i]  <= '0;
        attr_regs[i] <= tcw_pkg::ATTR_RESET;
      end
    end else begin
      done    <= 1'b0;
      s_valid <= 1'b0;
      case (state)
        // fill every cell with a blank of attribute zero
        ST_INIT: begin
          if (p == AW'(TOTAL - 1)) begin
            p     <= '0;
            state <= ST_IDLE;
          end else begin
            p <= AW'(p + AW'(1));
          end
        end

        ST_IDLE: begin
          if (start) begin
            f_reg <= func;
            t_reg <= term;
            c_reg <= char_code;
            i_reg <= cell_index;
            base  <= AW'(AW'(term) * AW'(CELLS));
            state <= ST_EXEC;
          end
        end

        ST_EXEC: begin
          p            <= '0;
          scrolled     <= 1'b0;
          refresh      <= 1'b0;
          read_char    <= '0;
          read_attr    <= '0;
          visible_term <= shown;
          cursor_pos   <= 11'(cur_now);
          state        <= ST_IDLE;
          done         <= 1'b1;
          if (!t_ok) begin
            cursor_pos <= '0;
          end else begin
            case (f_reg)
              tcw_pkg::FN_PUT: begin
                cur_regs[tsel] <= CUW'(cur_fin);
                col_regs[tsel] <= col_fin;
                cursor_pos     <= 11'(cur_fin);
                refresh        <= (t_reg == shown);
                if (wrap) begin
                  scrolled <= 1'b1;
                  done     <= 1'b0;
                  state    <= ST_SCROLL;
                end
              end
              tcw_pkg::FN_ATTR: begin
                attr_regs[tsel] <= c_reg;
              end
              tcw_pkg::FN_CLEAR: begin
                cur_regs[tsel] <= '0;
                col_regs[tsel] <= '0;
                cursor_pos     <= '0;
                refresh        <= (t_reg == shown);
                done           <= 1'b0;
                state          <= ST_CLEAR;
              end
              tcw_pkg::FN_SELECT: begin
                shown        <= t_reg;
                visible_term <= t_reg;
                refresh      <= 1'b1;
              end
              tcw_pkg::FN_READ: begin
                if (32'(i_reg) < CELLS) begin
                  done  <= 1'b0;
                  state <= ST_RDWAIT;
                end
              end
              default: begin
                state <= ST_IDLE;
              end
            endcase
          end
        end

        // cell data arrives from the registered read
        ST_RDWAIT: begin
          read_char <= ram_rdata[7:0];
          read_attr <= ram_rdata[15:8];
          done      <= 1'b1;
          state     <= ST_IDLE;
        end

        // move rows up one; the last row gets blanks
        ST_SCROLL: begin
          s_valid <= 1'b1;
          s_addr  <= AW'(base + p);
          s_blank <= !scroll_rd;
          s_clear <= 1'b0;
          if (sweep_end) begin
            state <= ST_FLUSH;
          end else begin
            p <= AW'(p + AW'(1));
          end
        end

        // character bytes to spaces, attributes kept
        ST_CLEAR: begin
          s_valid <= 1'b1;
          s_addr  <= AW'(base + p);
          s_blank <= 1'b0;
          s_clear <= 1'b1;
          if (sweep_end) begin
            state <= ST_FLUSH;
          end else begin
            p <= AW'(p + AW'(1));
          end
        end

        // last write-back of a sweep goes out this cycle
        ST_FLUSH: begin
          done  <= 1'b1;
          state <= ST_IDLE;
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  tcw_ram #(
    .WIDTH (16),
    .DEPTH (TOTAL)
  ) u_cells (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule
